@@ design/csfw_pkg.sv @@
`default_nettype none
package csfw_pkg;

	localparam int WAIT_DEPTH_DEF = 16;
	localparam int TASK_BITS_DEF = 8;
	localparam int COUNT_W = 8;
	localparam int STATUS_W = 2;

	localparam logic [STATUS_W-1:0] ST_OK = 2'd0;
	localparam logic [STATUS_W-1:0] ST_RELEASE_AT_ZERO = 2'd1;
	localparam logic [STATUS_W-1:0] ST_QUEUE_FULL = 2'd2;

	localparam logic [COUNT_W-1:0] LIMIT_RESET = 8'd1;

	localparam logic KIND_ACQUIRE = 1'b0;
	localparam logic KIND_RELEASE = 1'b1;

endpackage
`default_nettype wire

@@ design/counting_semaphore_fifo_waiters.sv @@
`default_nettype none
// Counting semaphore with a FIFO wait queue. Each transaction is an acquire (kind 0) or a
// release (kind 1) for task_id. An acquire is granted while the holder count is below
// holder_limit (written through cfg_we/cfg_wdata, reset value 1); otherwise the task joins
// a WAIT_DEPTH-entry wait queue and is reported blocked, or is dropped with status 2 when
// the queue is full. A release hands the semaphore to the oldest waiter (woken_valid,
// woken_task) or lowers the count; a release at count zero with an empty queue changes
// nothing and reports status 1. One request can be accepted every cycle while results
// are being taken. A result is registered in stage 1 and then in the result register
// before it is presented; the result register captures the registered wait queue RAM read.
// While out_stall holds a result, at most one more request is taken, then in_stall rises.
module counting_semaphore_fifo_waiters #(
	parameter int WAIT_DEPTH = csfw_pkg::WAIT_DEPTH_DEF,
	parameter int TASK_BITS = csfw_pkg::TASK_BITS_DEF
) (
	input  wire logic                             clk,
	input  wire logic                             arst_n,
	input  wire logic                             cfg_we,
	input  wire logic [csfw_pkg::COUNT_W-1:0]     cfg_wdata,
	input  wire logic                             in_valid,
	output logic                                  in_stall,
	input  wire logic                             kind,
	input  wire logic [TASK_BITS-1:0]             task_id,
	output logic                                  out_valid,
	input  wire logic                             out_stall,
	output logic                                  granted,
	output logic                                  blocked,
	output logic                                  woken_valid,
	output logic [TASK_BITS-1:0]                  woken_task,
	output logic [csfw_pkg::COUNT_W-1:0]          holders,
	output logic [csfw_pkg::STATUS_W-1:0]         status
);

	import csfw_pkg::*;

	localparam int PTR_W = $clog2(WAIT_DEPTH);
	localparam int FILL_W = $clog2(WAIT_DEPTH + 1);

	logic [COUNT_W-1:0]  limit_q;
	logic [COUNT_W-1:0]  count_q;
	logic [PTR_W-1:0]    head_q;
	logic [PTR_W-1:0]    tail_q;
	logic [FILL_W-1:0]   fill_q;

	logic                valid_s1;
	logic                granted_s1;
	logic                blocked_s1;
	logic                pop_s1;
	logic [COUNT_W-1:0]  holders_s1;
	logic [STATUS_W-1:0] status_s1;

	logic                valid_s2;
	logic                granted_s2;
	logic                blocked_s2;
	logic                woken_valid_s2;
	logic [TASK_BITS-1:0] woken_task_s2;
	logic [COUNT_W-1:0]  holders_s2;
	logic [STATUS_W-1:0] status_s2;

	logic                advance_s1;
	logic                accept;
	logic                can_grant;
	logic                queue_full;
	logic                queue_empty;
	logic                do_grant;
	logic                do_push;
	logic                do_pop;
	logic                do_dec;
	logic [COUNT_W-1:0]  count_nxt;
	logic [STATUS_W-1:0] status_nxt;
	logic [TASK_BITS-1:0] ram_rdata;

	// stage 1 moves on when the result register is free or being taken
	assign advance_s1 = !valid_s2 || !out_stall;
	assign in_stall = valid_s1 && !advance_s1;
	assign accept = in_valid && !in_stall;

	assign can_grant = count_q < limit_q;
	assign queue_full = fill_q == FILL_W'(WAIT_DEPTH);
	assign queue_empty = fill_q == '0;

	assign do_grant = accept && (kind == KIND_ACQUIRE) && can_grant;
	assign do_push = accept && (kind == KIND_ACQUIRE) && !can_grant && !queue_full;
	assign do_pop = accept && (kind == KIND_RELEASE) && !queue_empty;
	assign do_dec = accept && (kind == KIND_RELEASE) && queue_empty && (count_q != '0);

	always_comb begin
		count_nxt = count_q;
		if (do_grant) begin
			count_nxt = count_q + COUNT_W'(1);
		end else if (do_dec) begin
			count_nxt = count_q - COUNT_W'(1);
		end
	end

	always_comb begin
		status_nxt = ST_OK;
		if (kind == KIND_ACQUIRE) begin
			if (!can_grant && queue_full) begin
				status_nxt = ST_QUEUE_FULL;
			end
		end else if (queue_empty && (count_q == '0)) begin
			status_nxt = ST_RELEASE_AT_ZERO;
		end
	end

	function automatic logic [PTR_W-1:0] next_slot(input logic [PTR_W-1:0] p);
		logic [PTR_W-1:0] r;
		r = (p == PTR_W'(WAIT_DEPTH - 1)) ? '0 : p + PTR_W'(1);
		return r;
	endfunction

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			limit_q <= LIMIT_RESET;
		end else if (cfg_we) begin
			limit_q <= cfg_wdata;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
			head_q <= '0;
			tail_q <= '0;
			fill_q <= '0;
		end else begin
			count_q <= count_nxt;
			if (do_push) begin
				tail_q <= next_slot(tail_q);
				fill_q <= fill_q + FILL_W'(1);
			end else if (do_pop) begin
				head_q <= next_slot(head_q);
				fill_q <= fill_q - FILL_W'(1);
			end
		end
	end

	csfw_ram #(
		.WIDTH(TASK_BITS),
		.DEPTH(WAIT_DEPTH)
	) u_queue (
		.clk(clk),
		.we(do_push),
		.waddr(tail_q),
		.wdata(task_id),
		.re(do_pop),
		.raddr(head_q),
		.rdata(ram_rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (!in_stall) begin
			valid_s1 <= accept;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			granted_s1 <= do_grant;
			blocked_s1 <= do_push;
			pop_s1 <= do_pop;
			holders_s1 <= count_nxt;
			status_s1 <= status_nxt;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (advance_s1) begin
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (advance_s1 && valid_s1) begin
			granted_s2 <= granted_s1;
			blocked_s2 <= blocked_s1;
			woken_valid_s2 <= pop_s1;
			woken_task_s2 <= pop_s1 ? ram_rdata : '0;
			holders_s2 <= holders_s1;
			status_s2 <= status_s1;
		end
	end

	assign out_valid = valid_s2;
	assign granted = granted_s2;
	assign blocked = blocked_s2;
	assign woken_valid = woken_valid_s2;
	assign woken_task = woken_task_s2;
	assign holders = holders_s2;
	assign status = status_s2;

endmodule
`default_nettype wire

@@ design/csfw_ram.sv @@
`default_nettype none
module csfw_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic                     re,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output logic      [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule
`default_nettype wire

@@ design/csfw_checker.sv @@
`default_nettype none
module csfw_checker #(
	parameter int TASK_BITS = csfw_pkg::TASK_BITS_DEF
) (
	input wire logic                         clk,
	input wire logic                         arst_n,
	input wire logic                         out_valid,
	input wire logic                         out_stall,
	input wire logic                         granted,
	input wire logic                         blocked,
	input wire logic                         woken_valid,
	input wire logic [TASK_BITS-1:0]         woken_task,
	input wire logic [csfw_pkg::COUNT_W-1:0] holders,
	input wire logic [csfw_pkg::STATUS_W-1:0] status
);

	import csfw_pkg::*;

	// at most one outcome per transaction, and none on an error
	a_one_outcome: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> ($countones({granted, blocked, woken_valid}) <= 1)
			&& ((status == ST_OK) || !(granted || blocked || woken_valid)))
		else $error("more than one outcome in a result");

	a_woken_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && !woken_valid) |-> (woken_task == '0))
		else $error("woken_task set without a wake");

	a_count_sense: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (!granted || (holders != '0))
			&& ((status != ST_RELEASE_AT_ZERO) || (holders == '0)))
		else $error("holder count inconsistent with outcome");

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && out_stall) |=> out_valid && $stable(holders) && $stable(status))
		else $error("stalled result changed");

endmodule

bind counting_semaphore_fifo_waiters csfw_checker #(.TASK_BITS(TASK_BITS)) u_csfw_checker (.*);
`default_nettype wire

@@ verif/counting_semaphore_fifo_waiters_tb.sv @@
`default_nettype none
module counting_semaphore_fifo_waiters_tb;
	timeunit 1ns;
	timeprecision 1ps;

	import csfw_pkg::*;

	localparam int WATCHDOG_LIMIT = 1000;

	typedef struct packed {
		logic                granted;
		logic                blocked;
		logic                woken_valid;
		logic [7:0]          woken_task;
		logic [COUNT_W-1:0]  holders;
		logic [STATUS_W-1:0] status;
	} sem_result_t;

	class sem_scoreboard;
		logic [COUNT_W-1:0] limit;
		logic [COUNT_W-1:0] count;
		logic [7:0] waiters[$];
		sem_result_t pending_results[$];
		int errors;
		int n_req, n_grant, n_block, n_wake, n_zero, n_full;

		function new();
			limit = LIMIT_RESET;
			count = '0;
			errors = 0;
			n_req = 0;
			n_grant = 0;
			n_block = 0;
			n_wake = 0;
			n_zero = 0;
			n_full = 0;
		endfunction

		function void set_limit(logic [COUNT_W-1:0] v);
			limit = v;
		endfunction

		function int outstanding();
			return pending_results.size();
		endfunction

		function void note_request(logic k, logic [7:0] t);
			sem_result_t r;
			r = '0;
			n_req++;
			if (k == KIND_ACQUIRE) begin
				if (count < limit) begin
					count = count + 8'd1;
					r.granted = 1'b1;
					n_grant++;
				end else if (waiters.size() < WAIT_DEPTH_DEF) begin
					waiters.push_back(t);
					r.blocked = 1'b1;
					n_block++;
				end else begin
					r.status = ST_QUEUE_FULL;
					n_full++;
				end
			end else begin
				if (waiters.size() != 0) begin
					r.woken_task = waiters.pop_front();
					r.woken_valid = 1'b1;
					n_wake++;
				end else if (count != 0) begin
					count = count - 8'd1;
				end else begin
					r.status = ST_RELEASE_AT_ZERO;
					n_zero++;
				end
			end
			r.holders = count;
			pending_results.push_back(r);
		endfunction

		function void compare_field(string name, logic [7:0] want, logic [7:0] got);
			if (got !== want) begin
				$error("%s: expected %0h, got %0h", name, want, got);
				errors++;
			end
		endfunction

		function void check_result(sem_result_t got);
			sem_result_t want;
			if (pending_results.size() == 0) begin
				$error("result transaction with no request outstanding");
				errors++;
				return;
			end
			want = pending_results.pop_front();
			compare_field("granted", want.granted, got.granted);
			compare_field("blocked", want.blocked, got.blocked);
			compare_field("woken_valid", want.woken_valid, got.woken_valid);
			compare_field("woken_task", want.woken_task, got.woken_task);
			compare_field("holders", want.holders, got.holders);
			compare_field("status", want.status, got.status);
		endfunction
	endclass

	logic clk;
	logic arst_n;
	logic cfg_we;
	logic [COUNT_W-1:0] cfg_wdata;
	logic in_valid;
	logic in_stall;
	logic kind;
	logic [TASK_BITS_DEF-1:0] task_id;
	logic out_valid;
	logic out_stall;
	logic granted;
	logic blocked;
	logic woken_valid;
	logic [TASK_BITS_DEF-1:0] woken_task;
	logic [COUNT_W-1:0] holders;
	logic [STATUS_W-1:0] status;

	sem_scoreboard sb;
	bit calm;
	int n_settings;

	counting_semaphore_fifo_waiters dut (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg_we     (cfg_we),
		.cfg_wdata  (cfg_wdata),
		.in_valid   (in_valid),
		.in_stall   (in_stall),
		.kind       (kind),
		.task_id    (task_id),
		.out_valid  (out_valid),
		.out_stall  (out_stall),
		.granted    (granted),
		.blocked    (blocked),
		.woken_valid(woken_valid),
		.woken_task (woken_task),
		.holders    (holders),
		.status     (status)
	);

	initial clk = 1'b0;
	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	function automatic int gap_len();
		int r;
		if (calm)
			return 0;
		r = $urandom_range(0, 99);
		if (r < 65)
			return 0;
		if (r < 92)
			return $urandom_range(1, 3);
		return $urandom_range(8, 40);
	endfunction

	function automatic logic [7:0] pick_task();
		case ($urandom_range(0, 9))
			0: return 8'h00;
			1: return 8'hff;
			default: return 8'($urandom_range(0, 255));
		endcase
	endfunction

	task automatic send_request(input logic k, input logic [7:0] t);
		in_valid <= 1'b1;
		kind <= k;
		task_id <= t;
		@(posedge clk);
		while (in_stall)
			@(posedge clk);
		sb.note_request(k, t);
	endtask

	task automatic idle_sender(input int n);
		if (n > 0) begin
			in_valid <= 1'b0;
			repeat (n) @(posedge clk);
		end
	endtask

	task automatic drain_results();
		in_valid <= 1'b0;
		while (sb.outstanding() != 0)
			@(posedge clk);
		repeat (3) @(posedge clk);
	endtask

	task automatic write_limit(input logic [COUNT_W-1:0] v);
		drain_results();
		cfg_we <= 1'b1;
		cfg_wdata <= v;
		@(posedge clk);
		cfg_we <= 1'b0;
		sb.set_limit(v);
		n_settings++;
	endtask

	task automatic run_phase(input logic [COUNT_W-1:0] lim, input int n, input bit heavy);
		int sent;
		int bias;
		int run;
		int burst;
		write_limit(lim);
		sent = 0;
		burst = 0;
		while (sent < n) begin
			case ($urandom_range(0, 2))
				0: bias = 15;
				1: bias = 50;
				default: bias = 85;
			endcase
			if (heavy)
				bias = 97;
			run = $urandom_range(1, 24);
			calm = ($urandom_range(0, 3) == 0);
			// hold off until every outstanding result is back
			if (burst == 5)
				drain_results();
			for (int i = 0; i < run && sent < n; i++) begin
				idle_sender(gap_len());
				send_request(($urandom_range(0, 99) < bias) ? KIND_ACQUIRE : KIND_RELEASE,
					pick_task());
				sent++;
			end
			burst++;
		end
	endtask

	// receiver backpressure
	initial begin
		out_stall = 1'b0;
		forever begin
			@(posedge clk);
			if (calm || $urandom_range(0, 99) < 70) begin
				out_stall <= 1'b0;
			end else begin
				out_stall <= 1'b1;
				if ($urandom_range(0, 99) < 80)
					repeat ($urandom_range(1, 3)) @(posedge clk);
				else
					repeat ($urandom_range(8, 30)) @(posedge clk);
				out_stall <= 1'b0;
			end
		end
	end

	always @(posedge clk) begin
		if (arst_n && out_valid && !out_stall)
			sb.check_result('{granted, blocked, woken_valid, woken_task, holders, status});
	end

	initial begin
		int idle;
		idle = 0;
		while (idle < WATCHDOG_LIMIT) begin
			@(posedge clk);
			if ((in_valid && !in_stall) || (out_valid && !out_stall))
				idle = 0;
			else
				idle++;
		end
		$display("counting_semaphore_fifo_waiters regression: fail");
		$finish;
	end

	initial begin
		sb = new();
		calm = 1'b0;
		n_settings = 0;
		arst_n = 1'b0;
		cfg_we = 1'b0;
		cfg_wdata = '0;
		in_valid = 1'b0;
		kind = KIND_ACQUIRE;
		task_id = '0;
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// mutex: release at zero, hand-over in fifo order
		write_limit(LIMIT_RESET);
		send_request(KIND_RELEASE, 8'h00);
		send_request(KIND_ACQUIRE, 8'h00);
		send_request(KIND_ACQUIRE, 8'hff);
		send_request(KIND_ACQUIRE, 8'h5a);
		send_request(KIND_RELEASE, 8'hff);
		send_request(KIND_RELEASE, 8'h00);
		send_request(KIND_RELEASE, 8'h5a);
		send_request(KIND_RELEASE, 8'h00);

		// zero limit: every acquire waits
		write_limit(8'd0);
		send_request(KIND_ACQUIRE, 8'ha5);
		send_request(KIND_RELEASE, 8'h00);
		send_request(KIND_RELEASE, 8'h00);

		// limit lowered below the holder count
		write_limit(8'd3);
		send_request(KIND_ACQUIRE, 8'h01);
		send_request(KIND_ACQUIRE, 8'h02);
		send_request(KIND_ACQUIRE, 8'h03);
		write_limit(8'd1);
		send_request(KIND_ACQUIRE, 8'h04);
		send_request(KIND_RELEASE, 8'h01);
		send_request(KIND_RELEASE, 8'h02);
		send_request(KIND_RELEASE, 8'h03);
		send_request(KIND_RELEASE, 8'h04);

		run_phase(8'd1, 130, 1'b0);
		run_phase(8'd4, 130, 1'b0);
		run_phase(8'd255, 300, 1'b1);
		run_phase(8'd2, 130, 1'b0);

		calm = 1'b0;
		drain_results();
		$display("covered %0d requests under %0d holder limit settings", sb.n_req, n_settings);
		$display("grants %0d, blocks %0d, wakeups %0d, releases at zero %0d, full-queue drops %0d",
			sb.n_grant, sb.n_block, sb.n_wake, sb.n_zero, sb.n_full);
		if (sb.errors == 0 && sb.outstanding() == 0)
			$display("counting_semaphore_fifo_waiters regression: pass");
		else
			$display("counting_semaphore_fifo_waiters regression: fail");
		$finish;
	end

endmodule
`default_nettype wire
